FILE: hdl/ps2_keyboard_frame_receiver_top_assert.svh
// Assertion macros shared by the PS/2 frame receiver RTL.
`ifndef PS2_KEYBOARD_FRAME_RECEIVER_TOP_ASSERT_SVH
`define PS2_KEYBOARD_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PS2KFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2kfr: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PS2KFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2kfr: next-cycle check failed");

`endif

FILE: hdl/ps2kfr_pkg.sv
// Types, codes and scan code table for the PS/2 keyboard frame receiver.
package ps2kfr_pkg;

    // Frame phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RISE = 2'd1;
    localparam logic [1:0] PH_FALL = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_PARITY  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_HIGH_WAIT = 1'b0;
    localparam logic CFG_LOW_WAIT  = 1'b1;

    // Reset values of the wait limits
    localparam logic [7:0] HIGH_WAIT_RESET = 8'd255;
    localparam logic [7:0] LOW_WAIT_RESET  = 8'd200;

    // Special scan codes and characters
    localparam logic [7:0] CODE_BREAK    = 8'hF0;
    localparam logic [7:0] CODE_EXTENDED = 8'hE0;
    localparam logic [7:0] CHAR_UNKNOWN  = 8'h01;

    // Number of data bits in a frame
    localparam logic [3:0] DATA_BITS = 4'd8;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] character;
        logic [7:0] scan_code;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } frame_result_t;

    // Scan code set 2 to ASCII; unknown codes and prefixes give CHAR_UNKNOWN
    function automatic logic [7:0] code_to_char(input logic [7:0] code);
        logic [7:0] ch;
        ch = CHAR_UNKNOWN;
        unique case (code)
            CODE_BREAK:    ch = CHAR_UNKNOWN;
            CODE_EXTENDED: ch = CHAR_UNKNOWN;
            8'h1C: ch = 8'h61; // a
            8'h32: ch = 8'h62; // b
            8'h21: ch = 8'h63; // c
            8'h23: ch = 8'h64; // d
            8'h24: ch = 8'h65; // e
            8'h2B: ch = 8'h66; // f
            8'h34: ch = 8'h67; // g
            8'h33: ch = 8'h68; // h
            8'h43: ch = 8'h69; // i
            8'h3B: ch = 8'h6A; // j
            8'h42: ch = 8'h6B; // k
            8'h4B: ch = 8'h6C; // l
            8'h3A: ch = 8'h6D; // m
            8'h31: ch = 8'h6E; // n
            8'h44: ch = 8'h6F; // o
            8'h4D: ch = 8'h70; // p
            8'h15: ch = 8'h71; // q
            8'h2D: ch = 8'h72; // r
            8'h1B: ch = 8'h73; // s
            8'h2C: ch = 8'h74; // t
            8'h3C: ch = 8'h75; // u
            8'h2A: ch = 8'h76; // v
            8'h1D: ch = 8'h77; // w
            8'h22: ch = 8'h78; // x
            8'h35: ch = 8'h79; // y
            8'h1A: ch = 8'h7A; // z
            8'h45: ch = 8'h30; // 0
            8'h16: ch = 8'h31; // 1
            8'h1E: ch = 8'h32; // 2
            8'h26: ch = 8'h33; // 3
            8'h25: ch = 8'h34; // 4
            8'h2E: ch = 8'h35; // 5
            8'h36: ch = 8'h36; // 6
            8'h3D: ch = 8'h37; // 7
            8'h3E: ch = 8'h38; // 8
            8'h46: ch = 8'h39; // 9
            8'h4E: ch = 8'h2D; // -
            8'h55: ch = 8'h3D; // =
            8'h5B: ch = 8'h5D; // ]
            8'h54: ch = 8'h5B; // [
            8'h4C: ch = 8'h3B; // ;
            8'h29: ch = 8'h20; // space
            8'h5A: ch = 8'h0D; // enter
            8'h66: ch = 8'h08; // backspace
            default: ch = CHAR_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/ps2kfr_frame.sv
// Frame state machine: edge detect, bit shift, parity check and wait timeouts.
module ps2kfr_frame
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     clock_level,
    input  logic                     data_level,
    input  logic [7:0]               high_wait_limit,
    input  logic [7:0]               low_wait_limit,
    output ps2kfr_pkg::frame_result_t result
);

    logic [1:0] phase_reg,  phase_next;
    logic       prev_clk_reg, prev_clk_next;
    logic [3:0] bits_reg,   bits_next;
    logic [7:0] shift_reg,  shift_next;
    logic       parity_reg, parity_next;
    logic [7:0] ticks_reg,  ticks_next;

    logic [7:0] ticks_inc;
    logic       parity_ok;

    assign ticks_inc = ticks_reg + 8'd1;
    assign parity_ok = ((^shift_reg) ^ parity_reg) == 1'b1;

    // Next state and result for the current sample
    always_comb
    begin
        phase_next    = phase_reg;
        prev_clk_next = clock_level;
        bits_next     = bits_reg;
        shift_next    = shift_reg;
        parity_next   = parity_reg;
        ticks_next    = ticks_reg;
        result        = '0;

        unique case (phase_reg)
            ps2kfr_pkg::PH_RISE:
            begin
                if (clock_level)
                begin
                    phase_next = ps2kfr_pkg::PH_FALL;
                    ticks_next = '0;
                end
                else
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc == low_wait_limit)
                    begin
                        phase_next          = ps2kfr_pkg::PH_IDLE;
                        bits_next           = '0;
                        ticks_next          = '0;
                        result.valid        = 1'b1;
                        result.item.status  = ps2kfr_pkg::ST_TIMEOUT;
                    end
                end
            end
            ps2kfr_pkg::PH_FALL:
            begin
                if (!clock_level)
                begin
                    phase_next = ps2kfr_pkg::PH_RISE;
                    ticks_next = '0;
                    if (bits_reg < ps2kfr_pkg::DATA_BITS)
                    begin
                        shift_next = {data_level, shift_reg[7:1]};
                        bits_next  = bits_reg + 4'd1;
                    end
                    else if (bits_reg == ps2kfr_pkg::DATA_BITS)
                    begin
                        parity_next = data_level;
                        bits_next   = bits_reg + 4'd1;
                    end
                    else
                    begin
                        // stop bit: level not checked
                        phase_next            = ps2kfr_pkg::PH_IDLE;
                        bits_next             = '0;
                        result.valid          = 1'b1;
                        result.item.scan_code = shift_reg;
                        if (parity_ok)
                        begin
                            result.item.status    = ps2kfr_pkg::ST_OK;
                            result.item.character = ps2kfr_pkg::code_to_char(shift_reg);
                        end
                        else
                        begin
                            result.item.status = ps2kfr_pkg::ST_PARITY;
                        end
                    end
                end
                else
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc == high_wait_limit)
                    begin
                        phase_next         = ps2kfr_pkg::PH_IDLE;
                        bits_next          = '0;
                        ticks_next         = '0;
                        result.valid       = 1'b1;
                        result.item.status = ps2kfr_pkg::ST_TIMEOUT;
                    end
                end
            end
            default:
            begin
                // idle, or an unused code treated as idle
                phase_next = ps2kfr_pkg::PH_IDLE;
                bits_next  = '0;
                ticks_next = '0;
                if (prev_clk_reg && !clock_level && !data_level)
                begin
                    phase_next  = ps2kfr_pkg::PH_RISE;
                    shift_next  = '0;
                    parity_next = 1'b0;
                end
            end
        endcase

        if (!step)
        begin
            result.valid = 1'b0;
        end
    end

    // State registers, advanced once per accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ps2kfr_pkg::PH_IDLE;
            prev_clk_reg <= 1'b1;
            bits_reg     <= '0;
            shift_reg    <= '0;
            parity_reg   <= 1'b0;
            ticks_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            prev_clk_reg <= prev_clk_next;
            bits_reg     <= bits_next;
            shift_reg    <= shift_next;
            parity_reg   <= parity_next;
            ticks_reg    <= ticks_next;
        end
    end

endmodule

FILE: hdl/ps2_keyboard_frame_receiver_top.sv
// Top level of the PS/2 keyboard frame receiver: config, frame logic, output buffering.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | sink      | in_valid / in_ready   | clock_level, data_level
//  out     | source    | out_valid / out_ready | status, character, scan_code
//  cfg     | sink      | cfg_write_en          | cfg_index, cfg_data
//
// One sample per cycle while in_ready is high; a frame result is registered from the
// frame state logic into the output register, or into the skid register while the output is held.
// A one-entry skid register behind the output register keeps in_ready high
// while a result waits; in_ready drops only when both are full.
// Reset: idle phase, previous clock high, limits 255 and 200, no results held.
`include "ps2_keyboard_frame_receiver_top_assert.svh"

module ps2_keyboard_frame_receiver_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       clock_level,
    input  logic       data_level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] character,
    output logic [7:0] scan_code
);

    logic [7:0] high_wait_reg;
    logic [7:0] low_wait_reg;

    logic                      in_xfer;
    ps2kfr_pkg::frame_result_t result;

    logic              out_valid_reg,  out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    ps2kfr_pkg::item_t out_item_reg,   out_item_next;
    ps2kfr_pkg::item_t skid_item_reg,  skid_item_next;

    assign in_ready = !skid_valid_reg;
    assign in_xfer  = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_wait_reg <= ps2kfr_pkg::HIGH_WAIT_RESET;
            low_wait_reg  <= ps2kfr_pkg::LOW_WAIT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                ps2kfr_pkg::CFG_HIGH_WAIT: high_wait_reg <= cfg_data;
                ps2kfr_pkg::CFG_LOW_WAIT:  low_wait_reg  <= cfg_data;
                default:                   high_wait_reg <= high_wait_reg;
            endcase
        end
    end

    ps2kfr_frame u_frame
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (in_xfer),
        .clock_level     (clock_level),
        .data_level      (data_level),
        .high_wait_limit (high_wait_reg),
        .low_wait_limit  (low_wait_reg),
        .result          (result)
    );

    // Output register plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;

        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = result.valid;
                out_item_next  = result.item;
            end
            if (skid_valid_reg && result.valid)
            begin
                skid_valid_next = 1'b1;
                skid_item_next  = result.item;
            end
        end
        else if (result.valid)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = result.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_item_reg.status;
    assign character = out_item_reg.character;
    assign scan_code = out_item_reg.scan_code;

    // Skid entry only fills behind a held output
    `PS2KFR_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A waiting skid entry moves up, so the output stays occupied
    `PS2KFR_ASSERT_NEXT(a_skid_refills_out, skid_valid_reg, out_valid_reg)
    // Timeout results carry no code and no character
    `PS2KFR_ASSERT_NOW(a_timeout_empty,
        out_valid_reg && (status == ps2kfr_pkg::ST_TIMEOUT),
        (character == 8'd0) && (scan_code == 8'd0))
    // Parity errors carry no character
    `PS2KFR_ASSERT_NOW(a_parity_no_char,
        out_valid_reg && (status == ps2kfr_pkg::ST_PARITY), character == 8'd0)

endmodule
